// ===== rtl/dops_pkg.sv =====
// ----------------------------------------------------------------------------
// dops_pkg: shared types and constants
// Record layout, request codes and cell control for the date-ordered stack.
// ----------------------------------------------------------------------------
package dops_pkg;

    localparam int DEPTH             = 16;
    localparam int CNT_W             = $clog2(DEPTH + 1);
    localparam int LIMIT_W           = 5;
    localparam logic [LIMIT_W-1:0] MAX_ENTRIES_RESET = 5'd10;

    localparam int ID_W    = 16;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_POP    = 1'b1
    } req_type_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [ID_W-1:0]    id;
    } rec_t;

    typedef struct packed {
        logic insert;
        logic pop;
        rec_t new_rec;
    } cell_ctl_t;

    function automatic logic [KEY_W-1:0] date_key(input rec_t r);
        return {r.year, r.month, r.day};
    endfunction

endpackage

// ===== rtl/date_ordered_priority_stack.sv =====
// ----------------------------------------------------------------------------
// date_ordered_priority_stack: bounded stack of records, earliest date on top
// The result of each request is registered when the request transfers.
// Throughput: one request per cycle while m_tready holds; all cells compare and shift in parallel.
// Reset: synchronous active-low; empties the stack, limit returns to 10.
// Cell 0 is the top; cells below the count are valid.
// ----------------------------------------------------------------------------
module date_ordered_priority_stack (
    input  logic        aclk,
    input  logic        aresetn,
    // config
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,    // max_entries
    // request
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,     // record_id, key_day, key_month, key_year, pad
    input  logic        s_tuser,     // req_type
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // top_id, top_day, top_month, top_year,
                                     // entry_count, is_empty, pad
    output logic        m_tuser      // accepted
);

    localparam int N = dops_pkg::DEPTH;

    logic [dops_pkg::LIMIT_W-1:0] max_entries_reg;
    logic [dops_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [dops_pkg::CNT_W-1:0]   limit;
    logic                         m_valid_reg;
    logic [47:0]                  m_data_reg;
    logic                         m_user_reg;

    logic                 xfer;
    logic                 acc;
    dops_pkg::cell_ctl_t  ctl;
    dops_pkg::rec_t       in_rec;

    logic           stay  [N];
    logic           valid [N];
    dops_pkg::rec_t rec   [N];
    logic           vnext [N];
    dops_pkg::rec_t rnext [N];

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign xfer      = s_tvalid && s_tready;

    assign in_rec.id    = s_tdata[15:0];
    assign in_rec.day   = s_tdata[20:16];
    assign in_rec.month = s_tdata[24:21];
    assign in_rec.year  = s_tdata[40:25];

    always_comb begin
        if (dops_pkg::CNT_W'(max_entries_reg) < dops_pkg::CNT_W'(N)) begin
            limit = dops_pkg::CNT_W'(max_entries_reg);
        end else begin
            limit = dops_pkg::CNT_W'(N);
        end
        acc        = 1'b0;
        count_next = count_reg;
        if (dops_pkg::req_type_t'(s_tuser) == dops_pkg::REQ_INSERT) begin
            if (count_reg < limit) begin
                acc        = 1'b1;
                count_next = count_reg + 1'b1;
            end
        end else begin
            if (count_reg != '0) begin
                acc        = 1'b1;
                count_next = count_reg - 1'b1;
            end
        end
        ctl.new_rec = in_rec;
        ctl.insert  = xfer && acc &&
                      (dops_pkg::req_type_t'(s_tuser) == dops_pkg::REQ_INSERT);
        ctl.pop     = xfer && acc &&
                      (dops_pkg::req_type_t'(s_tuser) == dops_pkg::REQ_POP);
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic           up_stay;
        logic           up_valid;
        dops_pkg::rec_t up_rec;
        logic           dn_valid;
        dops_pkg::rec_t dn_rec;

        if (i == 0) begin : g_top
            assign up_stay  = 1'b1;
            assign up_valid = 1'b0;
            assign up_rec   = '0;
        end else begin : g_mid
            assign up_stay  = stay[i-1];
            assign up_valid = valid[i-1];
            assign up_rec   = rec[i-1];
        end
        if (i == N - 1) begin : g_bot
            assign dn_valid = 1'b0;
            assign dn_rec   = '0;
        end else begin : g_up
            assign dn_valid = valid[i+1];
            assign dn_rec   = rec[i+1];
        end

        dops_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .up_stay    (up_stay),
            .up_valid   (up_valid),
            .up_rec     (up_rec),
            .dn_valid   (dn_valid),
            .dn_rec     (dn_rec),
            .stay       (stay[i]),
            .valid      (valid[i]),
            .rec        (rec[i]),
            .valid_next (vnext[i]),
            .rec_next   (rnext[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= dops_pkg::MAX_ENTRIES_RESET;
            count_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_entries_reg <= cfg_data;
            end
            if (xfer) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (xfer) begin
            m_user_reg <= acc;
            if (vnext[0]) begin
                m_data_reg[40:0] <= rnext[0];
            end else begin
                m_data_reg[40:0] <= '0;
            end
            m_data_reg[45:41] <= 5'(count_next);
            m_data_reg[46]    <= (count_next == '0);
            m_data_reg[47]    <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== rtl/dops_cell.sv =====
// ----------------------------------------------------------------------------
// dops_cell: one slot of the sorted stack
// Holds one record; on insert keeps it, takes the new record or the upper
// neighbor's; on pop takes the lower neighbor's.
// ----------------------------------------------------------------------------
module dops_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  dops_pkg::cell_ctl_t ctl,
    input  logic              up_stay,
    input  logic              up_valid,
    input  dops_pkg::rec_t    up_rec,
    input  logic              dn_valid,
    input  dops_pkg::rec_t    dn_rec,
    output logic              stay,
    output logic              valid,
    output dops_pkg::rec_t    rec,
    output logic              valid_next,
    output dops_pkg::rec_t    rec_next
);

    logic           valid_reg;
    dops_pkg::rec_t rec_reg;

    assign valid = valid_reg;
    assign rec   = rec_reg;
    // record is earlier than the incoming one: stays above it
    assign stay  = valid_reg &&
                   (dops_pkg::date_key(rec_reg) < dops_pkg::date_key(ctl.new_rec));

    always_comb begin
        valid_next = valid_reg;
        rec_next   = rec_reg;
        if (ctl.insert) begin
            if (!stay) begin
                if (up_stay) begin
                    valid_next = 1'b1;
                    rec_next   = ctl.new_rec;
                end else begin
                    valid_next = up_valid;
                    rec_next   = up_rec;
                end
            end
        end else if (ctl.pop) begin
            valid_next = dn_valid;
            rec_next   = dn_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        rec_reg <= rec_next;
    end

endmodule
